// ----- hw/rtl/wsdd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsdd_pkg
// Shared types and constants for the WAV sample decoder with mono downmix.
// ----------------------------------------------------------------------------
package wsdd_pkg;

  localparam int MAX_CHANNELS = 8;

  localparam logic [1:0] CFG_FORMAT   = 2'd0;
  localparam logic [1:0] CFG_BYTES    = 2'd1;
  localparam logic [1:0] CFG_CHANNELS = 2'd2;

  localparam logic FMT_PCM   = 1'b0;
  localparam logic FMT_FLOAT = 1'b1;

  typedef struct packed {
    logic [63:0] gather;
    logic        fmt;
    logic [3:0]  bps;
    logic        last;
  } wsdd_samp_t;

  localparam int SAMP_W = $bits(wsdd_samp_t);

endpackage

// ----- hw/rtl/wsdd_front.sv -----
// ----------------------------------------------------------------------------
// wsdd_front
// Gathers bytes into samples and tags each with format and frame end.
// ----------------------------------------------------------------------------
module wsdd_front import wsdd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       clr,
  input  logic       fmt,
  input  logic [3:0] bps,
  input  logic [3:0] chans,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output wsdd_samp_t q_data
);

  logic [63:0] gather;
  logic [2:0]  bpos;
  logic [3:0]  cpos;
  logic        cfg_ok;
  logic        take;
  logic        done;
  logic [63:0] gather_next;

  always_comb begin
    cfg_ok = (chans != 4'd0) && ({28'd0, chans} <= 32'(MAX_CHANNELS));
    if (fmt == FMT_PCM) cfg_ok = cfg_ok && bps >= 4'd1 && bps <= 4'd4;
    else                cfg_ok = cfg_ok && (bps == 4'd4 || bps == 4'd8);
  end

  assign done        = ({1'b0, bpos} + 4'd1) == bps;
  assign in_ready    = !cfg_ok || !done || !q_valid || q_ready;
  assign take        = in_valid && in_ready && cfg_ok;
  assign gather_next = gather | ({56'd0, data_byte} << {bpos, 3'b000});

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      gather <= '0; bpos <= '0; cpos <= '0; q_valid <= 1'b0;
    end else begin
      if (take && done) q_valid <= 1'b1;
      else if (q_ready) q_valid <= 1'b0;
      if (take) begin
        if (done) begin
          q_data.gather  <= gather_next;
          q_data.fmt     <= fmt;
          q_data.bps     <= bps;
          q_data.last    <= (cpos + 4'd1) == chans;
          gather         <= '0;
          bpos           <= '0;
          cpos           <= ((cpos + 4'd1) == chans) ? 4'd0 : cpos + 4'd1;
        end else begin
          gather <= gather_next;
          bpos   <= bpos + 3'd1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/wsdd_back.sv -----
// ----------------------------------------------------------------------------
// wsdd_back
// Converts samples to Q1.31, sums a frame and divides by the channel count.
// ----------------------------------------------------------------------------
module wsdd_back import wsdd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        clr,
  input  logic [3:0]  chans,
  input  logic        q_valid,
  output logic        q_ready,
  input  wsdd_samp_t  q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] mono_sample,
  output logic        clipped
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t       state;
  logic signed [34:0] sum;
  logic         clip_acc;
  logic         clip_div;
  logic signed [31:0] conv;
  logic         conv_clip;
  logic signed [34:0] sum_next;
  logic         neg;
  logic [34:0]  rem;
  logic [34:0]  quo;
  logic [5:0]   cnt;
  logic [35:0]  trial;

  always_comb begin
    logic [63:0] g;
    logic [51:0] mant;
    logic [10:0] e;
    logic        sg;
    logic        nan, zer, big;
    logic signed [12:0] ex;
    logic [52:0] sig;
    logic [5:0]  sh;
    logic [52:0] mag;
    g = q_data.gather;
    conv_clip = 1'b0;
    mant = '0; e = '0; sg = 1'b0; nan = 1'b0; zer = 1'b0; big = 1'b0;
    ex = '0; sig = '0; sh = '0; mag = '0;
    if (q_data.fmt == FMT_PCM) begin
      unique case (q_data.bps)
        4'd1:    conv = {g[7:0] ^ 8'h80, 24'd0};
        4'd2:    conv = {g[15:0], 16'd0};
        4'd3:    conv = {g[23:0], 8'd0};
        default: conv = g[31:0];
      endcase
    end else begin
      if (q_data.bps == 4'd8) begin
        mant = g[51:0]; e = g[62:52]; sg = g[63];
        nan  = (e == 11'h7FF) && (mant != '0);
        big  = (e == 11'h7FF) || (e >= 11'd1023);
        ex   = $signed({2'b00, e}) - 13'sd1023;
        sig  = {1'b1, mant};
      end else begin
        mant = {g[22:0], 29'd0}; e = {3'd0, g[30:23]}; sg = g[31];
        nan  = (e == 11'hFF) && (mant != '0);
        big  = (e == 11'hFF) || (e >= 11'd127);
        ex   = $signed({2'b00, e}) - 13'sd127;
        sig  = {1'b1, mant};
      end
      zer = (e == '0);
      if (ex < -13'sd31) sh = 6'd63;
      else               sh = 6'(13'sd21 - ex);
      mag = (sh > 6'd52) ? '0 : (sig >> sh);
      if (nan || zer) conv = '0;
      else if (big) begin
        conv = sg ? 32'sh80000000 : 32'sh7FFFFFFF;
        conv_clip = !(sg && ex == 13'sd0 && mant == '0);
      end else conv = sg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    end
  end

  assign sum_next = sum + 35'(conv);
  assign q_ready  = (state == S_IDLE);
  assign trial    = {rem[34:0], quo[34]} - {32'd0, chans};

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      state <= S_IDLE; sum <= '0; clip_acc <= 1'b0; out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          if (q_data.last) begin
            neg      <= sum_next[34];
            quo      <= sum_next[34] ? 35'(-sum_next) : sum_next;
            rem      <= '0;
            cnt      <= 6'd35;
            clip_div <= clip_acc | conv_clip;
            sum      <= '0;
            clip_acc <= 1'b0;
            state    <= S_DIV;
          end else begin
            sum      <= sum_next;
            clip_acc <= clip_acc | conv_clip;
          end
        end
        S_DIV: begin
          if (!trial[35]) begin
            rem <= trial[34:0];
            quo <= {quo[33:0], 1'b1};
          end else begin
            rem <= {rem[33:0], quo[34]};
            quo <= {quo[33:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= S_OUT;
        end
        S_OUT: if (!out_valid || out_ready) begin
          mono_sample <= neg ? -$signed(quo[31:0]) : $signed(quo[31:0]);
          clipped     <= clip_div;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_div_len: assert property (@(posedge clk) disable iff (rst || clr)
    (state == S_DIV && cnt == 6'd1) |=> state == S_OUT)
    else $error("divide length");
  a_sum_clear: assert property (@(posedge clk) disable iff (rst || clr)
    (state == S_IDLE && q_valid && q_data.last) |=> sum == '0)
    else $error("frame sum not cleared");
`endif

endmodule

// ----- hw/rtl/wav_sample_decode_downmix.sv -----
// ----------------------------------------------------------------------------
// wav_sample_decode_downmix
// WAV data bytes to Q1.31 samples, averaged over channels to mono.
// ----------------------------------------------------------------------------
// channel  signals                              role
// in       in_valid in_ready data_byte          one data byte per item
// out      out_valid out_ready mono_sample clipped  one mono sample per frame
// cfg      cfg_valid cfg_ready cfg_index cfg_data   register write
// A byte is taken each cycle while the one-entry sample queue has room.
// The last sample of a frame holds the back end through accept, 35 restoring
// divide steps and output load; meanwhile the queue fills and input stalls.
// A result waiting on out_ready holds the back end in its output state.
// Reset and any register write clear the partial frame.
module wav_sample_decode_downmix import wsdd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] mono_sample,
  output logic        clipped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  logic       fmt;
  logic [3:0] bps;
  logic [3:0] chans;
  logic       clr;
  logic       q_valid, q_ready;
  wsdd_samp_t q_data;

  assign cfg_ready = 1'b1;
  assign clr = cfg_valid && (cfg_index == CFG_FORMAT || cfg_index == CFG_BYTES ||
                             cfg_index == CFG_CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_PCM; bps <= 4'd2; chans <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FORMAT:   fmt   <= cfg_data[0];
        CFG_BYTES:    bps   <= cfg_data;
        CFG_CHANNELS: chans <= cfg_data;
        default: ;
      endcase
    end
  end

  wsdd_front u_front (
    .clk, .rst, .clr, .fmt, .bps, .chans, .in_valid, .in_ready, .data_byte,
    .q_valid, .q_ready, .q_data
  );

  wsdd_back u_back (
    .clk, .rst, .clr, .chans, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .mono_sample, .clipped
  );

endmodule
